FILE: design/uist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package uist_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_SHIFT  = 2'd2,
        S_FINISH = 2'd3
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic    load;        // capture a new item, restart the scan pointer
        logic    clear;       // empty the set
        logic    scan;        // search step
        logic    start_shift; // begin compaction above the hit position
        logic    shift;       // compaction step
        logic    append;      // write key at the end, bump the count
        logic    dec;         // drop the count by one
        logic    set_status;  // latch status_code for the result
        status_t status_code;
        logic    emit;        // load the output register
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        op_t  op;       // operation of the item in work
        logic hit;      // entry just read matches the key
        logic drained;  // no read pending and pointer at the count
        logic full;     // count at capacity
        logic out_free; // output register can take a result
    } sts_t;

endpackage
`default_nettype wire

FILE: design/uist_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module uist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: design/uist_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module uist_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire uist_pkg::op_t  in_op,
    input  wire uist_pkg::sts_t sts,
    output uist_pkg::cmd_t      cmd
);
    import uist_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (in_op == OP_CLEAR)
                    begin
                        cmd.clear       = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_OK;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    case (sts.op)
                        OP_ADD:
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_DUP;
                            state_next      = S_FINISH;
                        end
                        OP_REMOVE:
                        begin
                            cmd.start_shift = 1'b1;
                            state_next      = S_SHIFT;
                        end
                        default:
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_OK;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
                else if (sts.drained)
                begin
                    cmd.set_status = 1'b1;
                    state_next     = S_FINISH;
                    if (sts.op == OP_ADD)
                    begin
                        if (sts.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.append      = 1'b1;
                            cmd.status_code = ST_OK;
                        end
                    end
                    else
                    begin
                        cmd.status_code = ST_ABSENT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.drained)
                begin
                    cmd.dec         = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/uist_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module uist_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire uist_pkg::op_t  in_op,
    input  wire logic [31:0]    in_key,
    input  wire uist_pkg::cmd_t cmd,
    output uist_pkg::sts_t      sts,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [1:0]          out_status,
    output logic [6:0]          out_total
);
    import uist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    op_t           op_reg;
    logic [31:0]   key_reg;
    logic [CW-1:0] count_reg,   count_next;
    logic [CW-1:0] addr_reg,    addr_next;
    logic          rd_vld_reg,  rd_vld_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    status_t       status_reg;
    logic          m_tvalid_reg;
    logic [1:0]    m_status_reg;
    logic [6:0]    m_total_reg;

    logic          rd_en;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          below;
    logic [CW+6:0] count_ext;

    uist_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // status back to the controller
    assign below        = addr_reg < count_reg;
    assign sts.op       = op_reg;
    assign sts.hit      = rd_vld_reg && (rd_data == key_reg);
    assign sts.drained  = !rd_vld_reg && !below;
    assign sts.full     = count_reg >= CAP_C;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // one read per step while the pointer is inside the set
    assign rd_en = (cmd.scan || cmd.shift) && below;

    // append at the end, or move the entry just read down one place
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = key_reg;
        if (cmd.append)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = cmp_idx_reg - AW'(1);
            wr_data = rd_data;
        end
    end

    // scan pointer and count
    always_comb
    begin
        addr_next    = addr_reg;
        rd_vld_next  = rd_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        count_next   = count_reg;
        if (cmd.load)
        begin
            addr_next   = '0;
            rd_vld_next = 1'b0;
        end
        else if (cmd.start_shift)
        begin
            addr_next   = CW'(cmp_idx_reg) + CW'(1);
            rd_vld_next = 1'b0;
        end
        else if (cmd.scan || cmd.shift)
        begin
            rd_vld_next = rd_en;
            if (rd_en)
            begin
                cmp_idx_next = addr_reg[AW-1:0];
                addr_next    = addr_reg + CW'(1);
            end
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            addr_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            rd_vld_reg <= rd_vld_next;
            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    assign count_ext = {7'd0, count_reg};

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        if (cmd.load)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.emit)
        begin
            m_status_reg <= status_reg;
            m_total_reg  <= count_ext[6:0];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_status = m_status_reg;
    assign out_total  = m_total_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("member count above capacity");

    // the closing step of a search may append; every other search step only reads
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && !cmd.append) |-> !wr_en)
        else $error("table written during search");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> count_reg == '0)
        else $error("clear left members behind");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && rd_vld_reg) |-> cmp_idx_reg != '0)
        else $error("compaction write below entry zero");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote one not yet taken");

endmodule
`default_nettype wire

FILE: design/unique_index_set_table.sv
// Clear answers without a search; add and check search the set member by member, and remove
//   also compacts the members above the removed one down one place.
// One item is in work at a time; the search and the compaction step through the one-read,
//   one-write table memory.
// The next item is taken while a result still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the set; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module unique_index_set_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] target_index
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [1:0] status, [8:2] member_total, [15:9] zero
);
    import uist_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    op_t        in_op;
    logic [1:0] out_status;
    logic [6:0] out_total;

    assign in_op = op_t'(s_tuser);

    uist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .sts      (sts),
        .cmd      (cmd)
    );

    uist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (in_op),
        .in_key     (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_total  (out_total)
    );

    assign m_tdata = {7'd0, out_total, out_status};

endmodule
`default_nettype wire
